### sv/fkscan_pkg.sv
// ----------------------------------------------------------------------------
// fkscan_pkg: shared types and constants of the four-key press scanner
// Holds the key and event word layouts and the reset values of the block.
// ----------------------------------------------------------------------------
package fkscan_pkg;

  localparam int COUNT_WIDTH_DEF  = 16;  // default hold counter width
  localparam int THRESH_WIDTH     = 16;  // width of the long press threshold
  localparam int IN_TDATA_WIDTH   = 8;   // five key bits padded to a byte
  localparam int OUT_TDATA_WIDTH  = 8;   // eight event bits

  localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = THRESH_WIDTH'(40);

  // One scan tick; power sits in bit 0.
  typedef struct packed {
    logic keys_enabled;
    logic down_pressed;
    logic up_pressed;
    logic mode_pressed;
    logic power_pressed;
  } keys_t;

  // Events of one tick; power_short sits in bit 0.
  typedef struct packed {
    logic down_long;
    logic down_short;
    logic up_long;
    logic up_short;
    logic mode_long;
    logic mode_short;
    logic power_long;
    logic power_short;
  } events_t;

endpackage

### sv/fkscan_engine.sv
// ----------------------------------------------------------------------------
// fkscan_engine: hold counters and priority chain
// Keeps one saturating hold counter per key and the down-key long latch,
// decodes the events of one tick and commits the state on step.
// ----------------------------------------------------------------------------
module fkscan_engine #(
  parameter int COUNT_WIDTH = fkscan_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  fkscan_pkg::keys_t                   keys,
  input  logic [fkscan_pkg::THRESH_WIDTH-1:0] threshold,
  output fkscan_pkg::events_t                 events
);
  import fkscan_pkg::*;

  localparam int CMP_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

  logic [COUNT_WIDTH-1:0] power_hold_count, power_hold_count_next;
  logic [COUNT_WIDTH-1:0] mode_hold_count,  mode_hold_count_next;
  logic [COUNT_WIDTH-1:0] up_hold_count,    up_hold_count_next;
  logic [COUNT_WIDTH-1:0] down_hold_count,  down_hold_count_next;
  logic                   down_long_latch,  down_long_latch_next;

  logic [COUNT_WIDTH-1:0] power_inc, mode_inc, up_inc, down_inc;
  logic [CMP_WIDTH-1:0]   thresh_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [CMP_WIDTH-1:0] widen(input logic [COUNT_WIDTH-1:0] c);
    widen = CMP_WIDTH'(c);
  endfunction

  assign power_inc  = sat_inc(power_hold_count);
  assign mode_inc   = sat_inc(mode_hold_count);
  assign up_inc     = sat_inc(up_hold_count);
  assign down_inc   = sat_inc(down_hold_count);
  assign thresh_ext = CMP_WIDTH'(threshold);

  always_comb begin
    events                = '0;
    power_hold_count_next = power_hold_count;
    mode_hold_count_next  = mode_hold_count;
    up_hold_count_next    = up_hold_count;
    down_hold_count_next  = down_hold_count;
    down_long_latch_next  = down_long_latch;

    if (keys.power_pressed) begin
      power_hold_count_next = power_inc;
      events.power_long     = (widen(power_inc) == thresh_ext) && keys.keys_enabled;
    end else if (power_hold_count != '0) begin
      events.power_short    = widen(power_hold_count) < thresh_ext;
      power_hold_count_next = '0;
    end else if (keys.mode_pressed && keys.keys_enabled) begin
      mode_hold_count_next = mode_inc;
      events.mode_long     = widen(mode_inc) == thresh_ext;
    end else if (mode_hold_count != '0 && !keys.mode_pressed) begin
      events.mode_short    = widen(mode_hold_count) < thresh_ext;
      mode_hold_count_next = '0;
    end else if (keys.up_pressed && keys.keys_enabled) begin
      up_hold_count_next = up_inc;
      events.up_long     = widen(up_inc) == thresh_ext;
    end else if (up_hold_count != '0 && !keys.up_pressed) begin
      events.up_short    = widen(up_hold_count) < thresh_ext;
      up_hold_count_next = '0;
    end else if (keys.down_pressed && keys.keys_enabled) begin
      down_hold_count_next = down_inc;
      if (widen(down_inc) == thresh_ext && !down_long_latch) begin
        events.down_long     = 1'b1;
        down_long_latch_next = 1'b1;
      end
    end else if (down_hold_count != '0 && !keys.down_pressed) begin
      events.down_short    = widen(down_hold_count) < thresh_ext;
      down_long_latch_next = 1'b0;
      down_hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_hold_count <= '0;
      mode_hold_count  <= '0;
      up_hold_count    <= '0;
      down_hold_count  <= '0;
      down_long_latch  <= 1'b0;
    end else if (step) begin
      power_hold_count <= power_hold_count_next;
      mode_hold_count  <= mode_hold_count_next;
      up_hold_count    <= up_hold_count_next;
      down_hold_count  <= down_hold_count_next;
      down_long_latch  <= down_long_latch_next;
    end
  end

endmodule

### sv/four_key_short_long_press_scanner.sv
// ----------------------------------------------------------------------------
// four_key_short_long_press_scanner: short/long press detector for four keys
// Turns scan ticks of four key levels into one event word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one scan tick per word: the power, mode, up and down key
//   levels plus the keys_enabled flag. m_* returns exactly one event word per
//   tick with the short and long events of the four keys; at most one bit is
//   set, since only the first matching branch of the priority chain acts.
//   cfg_* writes long_press_ticks, the held tick count at which a long event
//   fires; cfg_ready is always high. Write it only while the block is idle.
// Datapath and throughput:
//   A tick lands in the input register, the priority chain and the counter
//   update run between it and the output register, which offers the event
//   word on m_*. One tick is taken every cycle unless m_tready stalls the
//   output; the counter update loop sets that rate.
// Reset:
//   rst clears all hold counters, the down-key long latch and both valid
//   flags, and loads long_press_ticks with 40.
// Stall:
//   While m_tready is low the event word holds; the input register still
//   takes one more tick, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module four_key_short_long_press_scanner #(
  parameter int COUNT_WIDTH = fkscan_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // tdata: [0] power_pressed, [1] mode_pressed, [2] up_pressed,
  //        [3] down_pressed, [4] keys_enabled, [7:5] zero
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [fkscan_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
  // tdata: [0] power_short, [1] power_long, [2] mode_short, [3] mode_long,
  //        [4] up_short, [5] up_long, [6] down_short, [7] down_long
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fkscan_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
  // long_press_ticks write
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fkscan_pkg::THRESH_WIDTH-1:0]    cfg_data
);
  import fkscan_pkg::*;

  logic                    in_valid;
  keys_t                   in_keys;
  logic                    advance;
  events_t                 events;
  logic [THRESH_WIDTH-1:0] long_press_ticks;

  // Move the held tick on whenever the output slot is free or draining.
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      long_press_ticks <= cfg_data;
    end
  end

  // Input register: hold one tick until the chain consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_keys <= keys_t'(s_tdata[$bits(keys_t)-1:0]);
    end
  end

  // Counters and priority chain; state commits when the tick advances.
  fkscan_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .keys      (in_keys),
    .threshold (long_press_ticks),
    .events    (events)
  );

  // Output register: drop valid once taken, reload on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_TDATA_WIDTH'(events);
    end
  end

  // At most one event per word.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata))
    else $error("more than one event in a word");

  // No long event from a tick taken while keys are disabled.
  assert property (@(posedge clk) disable iff (rst)
    advance && !in_keys.keys_enabled |=>
      (m_tdata[1] == 1'b0 && m_tdata[3] == 1'b0 &&
       m_tdata[5] == 1'b0 && m_tdata[7] == 1'b0))
    else $error("long event while keys disabled");

  // An empty output slot never blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Mode, up and down events need the chain above them to be quiet.
  assert property (@(posedge clk) disable iff (rst)
    advance && in_keys.power_pressed |=>
      (m_tdata[OUT_TDATA_WIDTH-1:2] == '0))
    else $error("lower key event while power held");

endmodule
